// File: rtl/sgt_pkg.sv
// ----------------------------------------------------------------------------
// sgt_pkg
// Shared types, codes and helpers for the step sequencer with gate and tie.
// ----------------------------------------------------------------------------
package sgt_pkg;

  // Command carried in the input tuser
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_PULSE   = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ENABLED   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_EXT_CLOCK = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_INC = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_GATE_LEN  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRANSPOSE = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEQ_LEN   = 3'd5;
  localparam int unsigned CFG_DATA_W = 33;

  // Widest step address the table may need
  localparam int unsigned ADDR_W = 7;
  localparam logic [6:0]  NOTE_MAX = 7'd127;

  typedef struct packed {
    logic       tie;
    logic       gate;
    logic [6:0] note;
  } step_t;

  localparam step_t STEP_RESET = '{tie: 1'b0, gate: 1'b1, note: 7'd60};

  typedef struct packed {
    logic               we;
    logic               re;
    logic [ADDR_W-1:0]  addr;
    step_t              wdata;
  } mem_req_t;

  typedef struct packed {
    logic        enabled;
    logic        ext_clock;
    logic [31:0] phase_inc;
    logic [32:0] gate_len;
    logic [7:0]  transpose;
    logic [6:0]  seq_len;
  } cfg_t;

  // Result item, lowest field in the lowest bit
  typedef struct packed {
    logic       gate;
    logic       gate_change;
    logic [6:0] note;
    logic       note_change;
  } result_t;

  // Transposed note clamped to the MIDI range
  function automatic logic [6:0] eff_note(input logic [6:0] note,
                                          input logic [7:0] transpose);
    logic signed [8:0] sum;
    sum = $signed({2'b00, note}) + $signed({transpose[7], transpose});
    if (sum < 9'sd0) begin
      return 7'd0;
    end else if (sum > $signed({2'b00, NOTE_MAX})) begin
      return NOTE_MAX;
    end
    return sum[6:0];
  endfunction

endpackage

// File: rtl/sgt_step_ram.sv
// ----------------------------------------------------------------------------
// sgt_step_ram
// Step table: synchronous single-port memory with a registered read, with a
// valid bit per entry so that unwritten steps read as the default step.
// ----------------------------------------------------------------------------
module sgt_step_ram #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sgt_pkg::mem_req_t req_i,
  output sgt_pkg::step_t    rdata_o
);

  localparam int unsigned IDX_W = $clog2(MAX_STEPS);

  sgt_pkg::step_t        mem [MAX_STEPS];
  logic [MAX_STEPS-1:0]  valid_q;
  sgt_pkg::step_t        rd_q;
  logic                  rd_valid_q;
  logic [IDX_W-1:0]      addr;

  assign addr = req_i.addr[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[addr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[addr];
      end
    end
  end

  assign rdata_o = rd_valid_q ? rd_q : sgt_pkg::STEP_RESET;

endmodule

// File: rtl/sgt_ctrl.sv
// ----------------------------------------------------------------------------
// sgt_ctrl
// Sequencer control: phase, position and gate state, table read
// sequence, remainder unit for the position wrap and the output register.
// ----------------------------------------------------------------------------
module sgt_ctrl #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sgt_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sgt_pkg::cmd_e      cmd_i,
  input  logic [6:0]         step_index_i,
  input  sgt_pkg::step_t     step_i,
  output sgt_pkg::mem_req_t  mem_req_o,
  input  sgt_pkg::step_t     mem_rdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sgt_pkg::result_t   out_data_o
);

  localparam int unsigned IDX_W = $clog2(MAX_STEPS);
  localparam int unsigned LEN_W = $clog2(MAX_STEPS + 1);
  localparam int unsigned CNT_W = $clog2(LEN_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OLD  = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_NEW  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [31:0]      phase_q, phase_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic             gate_q, gate_d;
  logic             started_q, started_d;
  logic             pend_q, pend_d;
  logic             bnd_q, bnd_d;
  logic [6:0]       prev_note_q, prev_note_d;
  logic             prev_tie_q, prev_tie_d;
  sgt_pkg::result_t res_q, res_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0] dv_q, dv_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  sgt_pkg::result_t out_data_q, out_data_d;

  logic [LEN_W-1:0] eff_len;
  logic [7:0]       len_sat;
  logic             accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // Length 0 counts as 1, lengths above the table depth saturate
  always_comb begin
    if (cfg_i.seq_len == 7'd0) begin
      len_sat = 8'd1;
    end else if ({1'b0, cfg_i.seq_len} > 8'(MAX_STEPS)) begin
      len_sat = 8'(MAX_STEPS);
    end else begin
      len_sat = {1'b0, cfg_i.seq_len};
    end
  end
  assign eff_len = len_sat[LEN_W-1:0];

  always_comb begin
    logic [32:0]      sum;
    logic [LEN_W-1:0] nxt;
    logic [LEN_W:0]   r_sh;
    logic [LEN_W-1:0] r_new;
    logic [6:0]       note;
    logic             lvl;
    logic             tie;

    state_d     = state_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    gate_d      = gate_q;
    started_d   = started_q;
    pend_d      = pend_q;
    bnd_d       = bnd_q;
    prev_note_d = prev_note_q;
    prev_tie_d  = prev_tie_q;
    res_d       = res_q;
    rem_d       = rem_q;
    dv_d        = dv_q;
    cnt_d       = cnt_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_req_o   = '0;
    mem_req_o.addr = sgt_pkg::ADDR_W'(pos_q);

    sum   = {1'b0, phase_q} + {1'b0, cfg_i.phase_inc};
    nxt   = LEN_W'(pos_q) + LEN_W'(1);
    r_sh  = {rem_q, dv_q[LEN_W-1]};
    r_new = (r_sh >= {1'b0, eff_len}) ? LEN_W'(r_sh - {1'b0, eff_len})
                                      : r_sh[LEN_W-1:0];
    note  = sgt_pkg::eff_note(mem_rdata_i.note, cfg_i.transpose);
    lvl   = gate_q;
    tie   = mem_rdata_i.tie;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            sgt_pkg::CMD_WRITE: begin
              mem_req_o.we    = ({1'b0, step_index_i} < 8'(MAX_STEPS));
              mem_req_o.addr  = step_index_i;
              mem_req_o.wdata = step_i;
            end
            sgt_pkg::CMD_RESTART: begin
              phase_d   = '0;
              pos_d     = '0;
              gate_d    = 1'b0;
              started_d = 1'b0;
              pend_d    = 1'b0;
            end
            sgt_pkg::CMD_PULSE: begin
              pend_d = 1'b1;
            end
            default: begin
              res_d = '0;
              if (!cfg_i.enabled) begin
                phase_d = '0;
                if (gate_q) begin
                  gate_d            = 1'b0;
                  res_d.gate_change = 1'b1;
                end
                state_d = ST_EMIT;
              end else begin
                if (cfg_i.ext_clock) begin
                  bnd_d  = pend_q;
                  pend_d = 1'b0;
                end else begin
                  bnd_d   = sum[32];
                  phase_d = sum[31:0];
                end
                mem_req_o.re = 1'b1;
                state_d      = ST_OLD;
              end
            end
          endcase
        end
      end

      ST_OLD: begin
        prev_tie_d  = gate_q && mem_rdata_i.tie;
        prev_note_d = note;
        if (!bnd_q) begin
          // No boundary: only the gate length may end the gate
          if (!cfg_i.ext_clock && lvl && !tie && ({1'b0, phase_q} >= cfg_i.gate_len)) begin
            gate_d            = 1'b0;
            res_d.gate_change = 1'b1;
            res_d.gate        = 1'b0;
          end
          state_d = ST_EMIT;
        end else if (!started_q) begin
          started_d      = 1'b1;
          pos_d          = '0;
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = '0;
          state_d        = ST_NEW;
        end else if (nxt < eff_len) begin
          pos_d          = nxt[IDX_W-1:0];
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = sgt_pkg::ADDR_W'(nxt[IDX_W-1:0]);
          state_d        = ST_NEW;
        end else if (nxt == eff_len) begin
          pos_d          = '0;
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = '0;
          state_d        = ST_NEW;
        end else begin
          // Position beyond a shrunk length: wrap by restoring remainder
          rem_d   = '0;
          dv_d    = nxt;
          cnt_d   = CNT_W'(LEN_W - 1);
          state_d = ST_MOD;
        end
      end

      ST_MOD: begin
        rem_d = r_new;
        dv_d  = {dv_q[LEN_W-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          pos_d          = r_new[IDX_W-1:0];
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = sgt_pkg::ADDR_W'(r_new[IDX_W-1:0]);
          state_d        = ST_NEW;
        end
      end

      ST_NEW: begin
        res_d.note        = note;
        res_d.note_change = (note != prev_note_q) || !prev_tie_q;
        if (!mem_rdata_i.gate) begin
          if (lvl) begin
            lvl               = 1'b0;
            res_d.gate_change = 1'b1;
            res_d.gate        = 1'b0;
          end
        end else if (!lvl) begin
          lvl               = 1'b1;
          res_d.gate_change = 1'b1;
          res_d.gate        = 1'b1;
        end
        if (!cfg_i.ext_clock && lvl && !tie && ({1'b0, phase_q} >= cfg_i.gate_len)) begin
          lvl               = 1'b0;
          res_d.gate_change = 1'b1;
          res_d.gate        = 1'b0;
        end
        gate_d  = lvl;
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        // Hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_data_d  = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      pos_q       <= '0;
      gate_q      <= 1'b0;
      started_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      gate_q      <= gate_d;
      started_q   <= started_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bnd_q       <= bnd_d;
    prev_note_q <= prev_note_d;
    prev_tie_q  <= prev_tie_d;
    res_q       <= res_d;
    rem_q       <= rem_d;
    dv_q        <= dv_d;
    cnt_q       <= cnt_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/step_sequencer_gate_tie.sv
// ----------------------------------------------------------------------------
// step_sequencer_gate_tie
// Per-sample step sequencer with gate, tie, transpose and external clocking.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one command per transfer in tuser: sample tick,
//   step write, restart or external clock pulse. tdata holds the step fields
//   used by a write. Only a sample tick gives a result transfer, carrying the
//   note-change flag, the note, the gate-change flag and the gate level.
//   A step write, restart or pulse leaves the input ready again. A sample tick
//   reads the current step and emits without a step boundary, or reads the
//   current and next steps and emits with one; disabled, it emits without a
//   table read. A length shrunk below the position adds one remainder step
//   per length bit at the next boundary, before the dependent next-step read.
//   Reset clears the phase, position, gate and flags, loads the register
//   defaults and marks every step as the default step (note 60, gate on, no
//   tie) through per-entry valid bits; no clearing pass is needed.
//   A stalled receiver holds the result in the output register; the block
//   still takes the next transfer and holds the following result internally.
//   The user must write configuration only while the block is idle; the
//   block itself does not enforce it.
// ----------------------------------------------------------------------------
module step_sequencer_gate_tie #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [sgt_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [sgt_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [6:0] step_index, [13:7] step_note, [14] step_gate, [15] step_tie
  input  logic [15:0]                      s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]                       s_axis_tuser_i,
  // Result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] note_change, [7:1] note, [8] gate_change, [9] gate, [15:10] zero
  output logic [15:0]                      m_axis_tdata_o
);

  sgt_pkg::cfg_t     cfg_q;
  sgt_pkg::mem_req_t mem_req;
  sgt_pkg::step_t    mem_rdata;
  sgt_pkg::step_t    step_in;
  sgt_pkg::result_t  result;
  sgt_pkg::cmd_e     cmd;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled   <= 1'b0;
      cfg_q.ext_clock <= 1'b0;
      cfg_q.phase_inc <= '0;
      cfg_q.gate_len  <= 33'h0_8000_0000;
      cfg_q.transpose <= '0;
      cfg_q.seq_len   <= 7'd16;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sgt_pkg::CFG_ENABLED:   cfg_q.enabled   <= cfg_wdata_i[0];
        sgt_pkg::CFG_EXT_CLOCK: cfg_q.ext_clock <= cfg_wdata_i[0];
        sgt_pkg::CFG_PHASE_INC: cfg_q.phase_inc <= cfg_wdata_i[31:0];
        sgt_pkg::CFG_GATE_LEN:  cfg_q.gate_len  <= cfg_wdata_i[32:0];
        sgt_pkg::CFG_TRANSPOSE: cfg_q.transpose <= cfg_wdata_i[7:0];
        sgt_pkg::CFG_SEQ_LEN:   cfg_q.seq_len   <= cfg_wdata_i[6:0];
        default: begin
        end
      endcase
    end
  end

  // Unpack the input transfer
  assign cmd          = sgt_pkg::cmd_e'(s_axis_tuser_i);
  assign step_in.note = s_axis_tdata_i[13:7];
  assign step_in.gate = s_axis_tdata_i[14];
  assign step_in.tie  = s_axis_tdata_i[15];

  sgt_step_ram #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  sgt_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .cmd_i        (cmd),
    .step_index_i (s_axis_tdata_i[6:0]),
    .step_i       (step_in),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (result)
  );

  // Pad the result to whole bytes
  assign m_axis_tdata_o = {6'b0, result};

  // A command other than a sample tick never produces a result
  a_no_result_on_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i != sgt_pkg::CMD_TICK &&
     !m_axis_tvalid_o) |=> !m_axis_tvalid_o)
    else $error("result transfer appeared after a non-tick command");

  // A sample tick keeps the input closed while its table reads run
  a_tick_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == sgt_pkg::CMD_TICK)
    |=> !s_axis_tready_o)
    else $error("input accepted while a sample tick was in progress");

  // A raised gate level is only reported together with a gate change
  a_gate_with_change : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[9]) |-> m_axis_tdata_o[8])
    else $error("gate level set without gate change");

endmodule
